// ===== hdl/qfe_pkg.sv =====
package qfe_pkg;

   localparam int FEAT_BITS = 32;
   localparam int IDX_BITS = 6;
   localparam int LEN_BITS = 4;
   localparam logic [LEN_BITS-1:0] ROW_LENGTH_RESET = 4'd8;

   // Control that travels alongside a row store read
   typedef struct packed {
      logic                valid;
      logic                is_linear;
      logic [IDX_BITS-1:0] index;
      logic                last;
   } rd_tag_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_LINEAR  = 3'b010,
      ST_PRODUCT = 3'b100
   } seq_state_type;

endpackage

// ===== hdl/qfe_if.sv =====
interface qfe_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface qfe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] feature;
   logic               is_linear;
   logic [5:0]         feature_index;
   logic               last;

   modport source (output valid, output feature, output is_linear,
                   output feature_index, output last, input ready);
   modport sink (input valid, input feature, input is_linear,
                 input feature_index, input last, output ready);
endinterface

// ===== hdl/quadratic_feature_expander_unit.sv =====
// Channel | Dir | Handshake   | Payload
// req     | in  | valid/ready | sample (signed Q1.15, SAMPLE_BITS)
// rsp     | out | valid/ready | feature (Q2.30, 32), is_linear, feature_index (6), last
// csr     | in  | write_enable| write_data = row_length (4)
//
// A sample that does not close a row is written to the row store.
// The sample that closes a row of n starts a burst of n + n(n+1)/2 features, one per
// cycle while rsp is not stalled, read back from the row store; req.ready stays low
// while the sequencer issues the burst's reads.
// Reset (synchronous) clears the sample count, the sequencer and the output valid and
// loads row_length with 8; the row store is not cleared.
// A stall on rsp freezes the sequencer, the read pipeline and the output register.
module quadratic_feature_expander_unit
   import qfe_pkg::*;
#(
   parameter int MAX_DIM = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [LEN_BITS-1:0] csr_write_data,
   qfe_req_if.sink             req,
   qfe_rsp_if.source           rsp
);

   localparam int ADDR_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [LEN_BITS-1:0]  row_length_ff;
   logic [LEN_BITS-1:0]  count_ff, count_in;
   logic [LEN_BITS-1:0]  count_next;
   logic [LEN_BITS-1:0]  n_eff;
   logic                 accept;
   logic                 start;
   logic                 busy;
   logic                 advance;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;
   rd_tag_type           tag;

   // Clamp the row length: zero acts as one, anything above capacity as MAX_DIM
   always_comb begin
      if (row_length_ff == '0) begin
         n_eff = LEN_BITS'(1);
      end else if (row_length_ff > LEN_BITS'(MAX_DIM)) begin
         n_eff = LEN_BITS'(MAX_DIM);
      end else begin
         n_eff = row_length_ff;
      end
   end

   // Take samples only between bursts
   assign req.ready = !busy;
   assign accept = req.valid && !busy;

   // Close the row once the count reaches the effective length, even if the
   // length shrank mid-row
   assign count_next = LEN_BITS'(count_ff + 1'b1);
   assign start = accept && (count_next >= n_eff);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = start ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            row_length_ff <= csr_write_data;
         end
         count_ff <= count_in;
      end
   end

   // Row store: written by accepted samples, read back by the sequencer
   qfe_ram #(
      .WIDTH     (SAMPLE_BITS),
      .DEPTH     (MAX_DIM),
      .ADDR_BITS (ADDR_BITS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (req.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Walk j and k over the stored row, issuing one read per feature
   qfe_seq #(
      .ADDR_BITS (ADDR_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .start   (start),
      .n_eff   (n_eff),
      .busy    (busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .tag     (tag)
   );

   // Hold x_j, form the linear term or the product, and register the result
   qfe_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .tag     (tag),
      .rd_data (rd_data),
      .advance (advance),
      .rsp     (rsp)
   );

endmodule

// ===== hdl/qfe_ram.sv =====
module qfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/qfe_seq.sv =====
module qfe_seq
   import qfe_pkg::*;
#(
   parameter int ADDR_BITS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 start,
   input  logic [LEN_BITS-1:0]  n_eff,
   output logic                 busy,
   output logic                 rd_en,
   output logic [ADDR_BITS-1:0] rd_addr,
   output rd_tag_type           tag
);

   seq_state_type        state_ff, state_in;
   logic [ADDR_BITS-1:0] j_ff, j_in;
   logic [ADDR_BITS-1:0] k_ff, k_in;
   logic [IDX_BITS-1:0]  idx_ff, idx_in;
   rd_tag_type           tag_ff, tag_in;
   logic                 j_last;
   logic                 k_last;

   assign j_last = LEN_BITS'(j_ff) == n_eff - LEN_BITS'(1);
   assign k_last = LEN_BITS'(k_ff) == n_eff - LEN_BITS'(1);

   always_comb begin
      state_in = state_ff;
      j_in = j_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      rd_en = 1'b0;
      rd_addr = (state_ff == ST_LINEAR) ? j_ff : k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LINEAR;
               j_in = '0;
               k_in = '0;
               idx_in = '0;
            end
         end
         ST_LINEAR: begin
            if (advance) begin
               rd_en = 1'b1;
               state_in = ST_PRODUCT;
               k_in = j_ff;
               idx_in = IDX_BITS'(idx_ff + 1'b1);
            end
         end
         ST_PRODUCT: begin
            if (advance) begin
               rd_en = 1'b1;
               idx_in = IDX_BITS'(idx_ff + 1'b1);
               if (k_last) begin
                  if (j_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     j_in = ADDR_BITS'(j_ff + 1'b1);
                     state_in = ST_LINEAR;
                  end
               end else begin
                  k_in = ADDR_BITS'(k_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Tag is registered with the read, so it lines up with the registered read data
   always_comb begin
      tag_in = tag_ff;
      if (advance) begin
         tag_in.valid = state_ff != ST_IDLE;
         tag_in.is_linear = state_ff == ST_LINEAR;
         tag_in.index = idx_ff;
         tag_in.last = (state_ff == ST_PRODUCT) && k_last && j_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff.valid <= tag_in.valid;
      end
      j_ff <= j_in;
      k_ff <= k_in;
      idx_ff <= idx_in;
      tag_ff.is_linear <= tag_in.is_linear;
      tag_ff.index <= tag_in.index;
      tag_ff.last <= tag_in.last;
   end

   assign busy = state_ff != ST_IDLE;
   assign tag = tag_ff;

endmodule

// ===== hdl/qfe_dp.sv =====
module qfe_dp
   import qfe_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rd_tag_type             tag,
   input  logic [SAMPLE_BITS-1:0] rd_data,
   output logic                   advance,
   qfe_rsp_if.source              rsp
);

   localparam int PW = 2 * SAMPLE_BITS;

   logic signed [SAMPLE_BITS-1:0] xj_ff;
   logic signed [SAMPLE_BITS-1:0] xk;
   logic signed [PW-1:0]          lin;
   logic signed [PW-1:0]          prod;
   logic signed [FEAT_BITS-1:0]   feature_in;
   logic                          out_valid_ff;
   logic signed [FEAT_BITS-1:0]   feature_ff;
   logic                          is_linear_ff;
   logic [IDX_BITS-1:0]           index_ff;
   logic                          last_ff;

   // Move when the output register is empty or being drained
   assign advance = !out_valid_ff || rsp.ready;

   assign xk = signed'(rd_data);
   assign lin = PW'(xk) <<< (SAMPLE_BITS - 1);
   assign prod = xj_ff * xk;
   assign feature_in = tag.is_linear ? FEAT_BITS'(lin) : FEAT_BITS'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= tag.valid;
      end
      if (advance && tag.valid && tag.is_linear) begin
         xj_ff <= xk;
      end
      if (advance) begin
         feature_ff <= feature_in;
         is_linear_ff <= tag.is_linear;
         index_ff <= tag.index;
         last_ff <= tag.last;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.feature = feature_ff;
   assign rsp.is_linear = is_linear_ff;
   assign rsp.feature_index = index_ff;
   assign rsp.last = last_ff;

endmodule

// ===== tb/feature_expansion_check.sv =====
`timescale 1ns / 100ps

module feature_expansion_check
   import qfe_pkg::*;
#(
   parameter int MAX_DIM = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [LEN_BITS-1:0] csr_write_data,
   qfe_req_if                  req,
   qfe_rsp_if                  rsp,
   output int                  error_count,
   output int                  pending_features,
   output int                  features_checked
);

   typedef struct packed {
      logic signed [FEAT_BITS-1:0] feature;
      logic                        is_linear;
      logic [IDX_BITS-1:0]         index;
      logic                        last;
   } feature_rec_type;

   logic signed [SAMPLE_BITS-1:0] row_store [MAX_DIM];
   logic [LEN_BITS-1:0]           row_len;
   logic [LEN_BITS-1:0]           fill;
   feature_rec_type               expected_features [$];
   int                            errors;
   int                            checked;

   function automatic int unsigned active_length();
      if (row_len == 0)
         return 1;
      if (row_len > MAX_DIM)
         return MAX_DIM;
      return row_len;
   endfunction

   // Queue the whole burst for a completed row: linear term, then its products
   function automatic void expand_row(input int unsigned n);
      int unsigned       pos;
      int unsigned       total;
      logic signed [63:0] xj;
      logic signed [63:0] xk;
      feature_rec_type   rec;
      pos = 0;
      total = n + (n * (n + 1)) / 2;
      for (int unsigned j = 0; j < n; j++) begin
         xj = row_store[j];
         rec.feature = FEAT_BITS'(xj <<< (SAMPLE_BITS - 1));
         rec.is_linear = 1'b1;
         rec.index = IDX_BITS'(pos);
         rec.last = (pos + 1 == total);
         expected_features.push_back(rec);
         pos++;
         for (int unsigned k = j; k < n; k++) begin
            xk = row_store[k];
            rec.feature = FEAT_BITS'(xj * xk);
            rec.is_linear = 1'b0;
            rec.index = IDX_BITS'(pos);
            rec.last = (pos + 1 == total);
            expected_features.push_back(rec);
            pos++;
         end
      end
   endfunction

   function automatic void store_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int unsigned n;
      n = active_length();
      if (fill < MAX_DIM)
         row_store[fill] = value;
      fill = fill + 1'b1;
      if (fill >= n) begin
         fill = '0;
         expand_row(n);
      end
   endfunction

   function automatic void report(input string field, input longint want, input longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      feature_rec_type want;
      if (reset) begin
         row_len = ROW_LENGTH_RESET;
         fill = '0;
         expected_features.delete();
      end else begin
         if (csr_write_enable)
            row_len = csr_write_data;
         if (req.valid && req.ready)
            store_sample(req.sample);
         if (rsp.valid && rsp.ready) begin
            checked++;
            if (expected_features.size() == 0) begin
               report("unexpected feature", 0, rsp.feature);
            end else begin
               want = expected_features.pop_front();
               if (rsp.feature !== want.feature)
                  report("feature", want.feature, rsp.feature);
               if (rsp.is_linear !== want.is_linear)
                  report("is_linear", want.is_linear, rsp.is_linear);
               if (rsp.feature_index !== want.index)
                  report("feature_index", want.index, rsp.feature_index);
               if (rsp.last !== want.last)
                  report("last", want.last, rsp.last);
            end
         end
      end
      error_count <= errors;
      pending_features <= expected_features.size();
      features_checked <= checked;
   end

endmodule

// ===== tb/tb_quadratic_feature_expander_unit.sv =====
`timescale 1ns / 100ps

module tb_quadratic_feature_expander_unit;
   import qfe_pkg::*;

   localparam int MAX_DIM = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 21;
   localparam int PRESSURE_ITEMS = 16;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable;
   logic [LEN_BITS-1:0] csr_write_data;
   logic                rsp_hold;
   logic                hold_kick = 1'b0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  samples_sent = 0;
   int                  length_writes = 0;
   int                  cycle_count = 0;
   int                  error_count;
   int                  pending_features;
   int                  features_checked;

   qfe_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   qfe_rsp_if rsp_ch ();

   quadratic_feature_expander_unit #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   // Watch both channels, predict each row's burst and compare
   feature_expansion_check #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) expansion_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .error_count      (error_count),
      .pending_features (pending_features),
      .features_checked (features_checked)
   );

   always #10 clock = ~clock;

   // Receiver: stall at the phase's rate, and stall throughout while the hold-off runs
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
   end

   // Long receiver hold-off: block the output so the burst backs up into req.ready
   initial begin
      rsp_hold = 1'b0;
      wait (hold_kick);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog: end the run as failed when cycle_count reaches CYCLE_LIMIT
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_quadratic_feature_expander_unit failed");
      $finish;
   end

   // Full-scale random samples half the time, with the extremes, zero and -1 mixed in
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(7))
         0: return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
         1: return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
         2: return '0;
         3: return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 59;
            stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct <= 59;
         end
         default: begin
            send_idle_pct = 19;
            stall_pct <= 19;
         end
      endcase
   endtask

   // Offer one item, idling first at the sender's rate; return in the accepting step
   // with valid still high, so the caller either offers the next item or drops valid.
   task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= value;
      do @(posedge clock); while (!req_ch.ready);
      samples_sent++;
   endtask

   // Drop valid and wait until every expected feature is back, then let the
   // block finish storing any sample that closed no row.
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_features != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_length(input logic [LEN_BITS-1:0] len);
      settle_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_writes++;
   endtask

   initial begin
      logic signed [SAMPLE_BITS-1:0] edge_row [8];
      logic [LEN_BITS-1:0]           phase_len [RANDOM_PHASES];
      logic [LEN_BITS-1:0]           len;

      edge_row = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
                   16'shFFFF, 16'sh4000, 16'shC000, 16'sh5555};
      phase_len = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd5};

      // Hold every input at a known value from time zero
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // Directed: a full row at the reset length of 8 with both extremes,
      // zero and +/-1; the most negative sample squared gives the largest feature.
      foreach (edge_row[i])
         offer_sample(edge_row[i]);

      // Single-sample rows, then a zero length that must behave as one
      write_row_length(4'd1);
      offer_sample(16'sh8000);
      write_row_length(4'd0);
      offer_sample(16'sh7FFF);

      // Length beyond capacity folds down to the store depth
      write_row_length(4'd15);
      repeat (MAX_DIM) offer_sample(pick_sample());

      // Shrink the length mid-row: the next sample closes the row early and
      // only the first two stored samples are expanded.
      write_row_length(4'd5);
      repeat (3) offer_sample(pick_sample());
      write_row_length(4'd2);
      offer_sample(pick_sample());

      // Random phases: cycle through the idling modes and a spread of lengths;
      // phases end mid-row at times, so later writes also land mid-row.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         len = phase_len[ph];
         if (ph >= RANDOM_PHASES - 2)
            len = LEN_BITS'($urandom_range(15));
         write_row_length(len);
         set_idling(idle_mode_type'(ph % 4));
         repeat (ITEMS_PER_PHASE) offer_sample(pick_sample());
      end

      // Pressure: full-length rows offered back to back while the receiver
      // holds off, so the output backs up and the input stalls.
      write_row_length(4'd8);
      set_idling(IDLE_NONE);
      hold_kick = 1'b1;
      repeat (PRESSURE_ITEMS) offer_sample(pick_sample());

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_features != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d samples across %0d row length settings, %0d features compared.",
               samples_sent, length_writes, features_checked);
      $display("Phases: idle-free, sender-idle, receiver-stall, mixed; %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("tb_quadratic_feature_expander_unit passed");
      else
         $display("tb_quadratic_feature_expander_unit failed");
      $finish;
   end

endmodule
